// ===== src/b64d_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base64 decoder.
// No dependencies; every other file imports this package.
package b64d_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_PAD    = 8'h3D; // '='
    localparam logic [6:0] SEXTET_BAD  = 7'd64;
    localparam logic [6:0] LOWER_BASE  = 7'd26;
    localparam logic [6:0] DIGIT_BASE  = 7'd52;
    localparam logic [6:0] SEXTET_PLUS = 7'd62;
    localparam logic [6:0] SEXTET_DIV  = 7'd63;

    // Position of the status result in a work mask
    localparam logic [1:0] SLOT_STATUS = 2'd3;

    // One unit of work handed from the front to the back
    typedef struct packed {
        logic [2:0][7:0] data;   // decoded bytes of a group
        logic [2:0]      keep;   // bytes to emit, already limited
        logic            status; // end-of-text status follows
        logic            halt;   // halt flag for the status word
        logic [15:0]     base;   // byte count before this group
    } entry_t;

    // 0..63 for an alphabet character, SEXTET_BAD otherwise
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'd0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            d = ch - 8'h41;
            return d[6:0];
        end
        if (ch >= 8'h61 && ch <= 8'h7A) begin
            d = ch - 8'h61;
            return d[6:0] + LOWER_BASE;
        end
        if (ch >= 8'h30 && ch <= 8'h39) begin
            d = ch - 8'h30;
            return d[6:0] + DIGIT_BASE;
        end
        if (ch == 8'h2B) return SEXTET_PLUS;
        if (ch == 8'h2F) return SEXTET_DIV;
        return SEXTET_BAD;
    endfunction

endpackage

// ===== src/b64d_front.sv =====
// Front end: accepts characters, tracks group state and the byte count,
// and builds one work entry per group that yields bytes or per end of text. Uses b64d_pkg.
module b64d_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        char_code,
    input  logic              end_of_text,
    input  logic [15:0]       limit,
    output logic              push,
    output b64d_pkg::entry_t  entry
);
    import b64d_pkg::*;

    logic [1:0]      pos_reg,   pos_next;
    logic [2:0][5:0] held_reg,  held_next;
    logic            tpad_reg,  tpad_next;
    logic            stop_reg,  stop_next;
    logic            bad_reg,   bad_next;
    logic [15:0]     count_reg, count_next;

    logic [6:0]  sx;
    logic        pad;
    logic        char_bad;
    logic [5:0]  v;
    logic        under;
    logic [15:0] room;
    logic [1:0]  avail;
    logic [1:0]  rank2;
    logic [2:0]  keep;
    logic        emit;
    logic        set_stop;

    always_comb
    begin
        sx       = sextet_of(char_code);
        pad      = (char_code == CHAR_PAD);
        char_bad = 1'b0;
        v        = sx[5:0];
        if (pos_reg[1] && pad) begin
            v = 6'd0;
        end else if (sx == SEXTET_BAD) begin
            char_bad = 1'b1;
            v        = 6'd0;
        end

        under = (count_reg < limit);
        room  = limit - count_reg;
        avail = (room >= 16'd3) ? 2'd3 : room[1:0];
        rank2 = tpad_reg ? 2'd1 : 2'd2;

        emit     = !stop_reg && (pos_reg == 2'd3) && under && !(bad_reg || char_bad);
        set_stop = !stop_reg && (pos_reg == 2'd3) && under && (bad_reg || char_bad);

        keep[0] = emit && (avail > 2'd0);
        keep[1] = emit && !tpad_reg && (avail > 2'd1);
        keep[2] = emit && !pad && (avail > rank2);

        entry.data[0] = {held_reg[0], held_reg[1][5:4]};
        entry.data[1] = {held_reg[1][3:0], held_reg[2][5:2]};
        entry.data[2] = {held_reg[2][1:0], v};
        entry.keep    = keep;
        entry.status  = end_of_text;
        entry.halt    = stop_reg || set_stop;
        entry.base    = count_reg;
        push          = accept && ((|keep) || end_of_text);

        pos_next   = pos_reg;
        held_next  = held_reg;
        tpad_next  = tpad_reg;
        stop_next  = stop_reg;
        bad_next   = bad_reg;
        count_next = count_reg;

        if (accept) begin
            if (!stop_reg) begin
                case (pos_reg)
                    2'd0:
                    begin
                        held_next[0] = v;
                        bad_next     = bad_reg || char_bad;
                        pos_next     = 2'd1;
                    end
                    2'd1:
                    begin
                        held_next[1] = v;
                        bad_next     = bad_reg || char_bad;
                        pos_next     = 2'd2;
                    end
                    2'd2:
                    begin
                        held_next[2] = v;
                        tpad_next    = pad;
                        bad_next     = bad_reg || char_bad;
                        pos_next     = 2'd3;
                    end
                    default:
                    begin
                        // close the group: count its bytes or halt
                        count_next = count_reg + 16'(keep[0]) + 16'(keep[1])
                                     + 16'(keep[2]);
                        stop_next  = set_stop;
                        pos_next   = 2'd0;
                        tpad_next  = 1'b0;
                        bad_next   = 1'b0;
                    end
                endcase
            end
            if (end_of_text) begin
                // drop all per-text state
                pos_next   = 2'd0;
                held_next  = '0;
                tpad_next  = 1'b0;
                stop_next  = 1'b0;
                bad_next   = 1'b0;
                count_next = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg   <= 2'd0;
            held_reg  <= '0;
            tpad_reg  <= 1'b0;
            stop_reg  <= 1'b0;
            bad_reg   <= 1'b0;
            count_reg <= 16'd0;
        end else begin
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            tpad_reg  <= tpad_next;
            stop_reg  <= stop_next;
            bad_reg   <= bad_next;
            count_reg <= count_next;
        end
    end

    // a halted text sits with an empty group
    a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> (pos_reg == 2'd0) && !bad_reg && !tpad_reg)
        else $error("halted text with open group");

    // a halting group emits no bytes
    a_halt_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        set_stop |-> keep == 3'b000)
        else $error("bytes emitted on halt");

endmodule

// ===== src/b64d_queue.sv =====
// Small register queue of work entries between front and back.
// Uses b64d_pkg for the entry type.
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64d_pkg::entry_t  push_entry,
    input  logic              pop,
    output b64d_pkg::entry_t  head,
    output logic              full,
    output logic              not_empty
);
    import b64d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t        slot_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ((wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = pop  ? ((rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue underflow");

endmodule

// ===== src/b64d_back.sv =====
// Back end: unpacks one work entry into data and status words, one per
// cycle while the receiver is ready, into an output register. Uses b64d_pkg.
module b64d_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  b64d_pkg::entry_t  q_head,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              is_data,
    output logic              last_of_run,
    output logic [15:0]       bytes_so_far,
    output logic              halted
);
    import b64d_pkg::*;

    entry_t      cur_reg;
    logic        cur_valid_reg, cur_valid_next;
    logic [3:0]  rem_reg, rem_next;
    logic [1:0]  done_reg, done_next;
    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg;
    logic        od_reg;
    logic        ol_reg;
    logic [15:0] oc_reg;
    logic        oh_reg;

    logic [1:0]  sel;
    logic [3:0]  left;
    logic        adv;
    logic        fin;
    logic        sel_data;

    always_comb
    begin
        // lowest pending slot goes first
        if (rem_reg[0])      sel = 2'd0;
        else if (rem_reg[1]) sel = 2'd1;
        else if (rem_reg[2]) sel = 2'd2;
        else                 sel = SLOT_STATUS;
        sel_data = (sel != SLOT_STATUS);
        left     = rem_reg & ~(4'b0001 << sel);
        adv      = cur_valid_reg && (!ov_reg || out_ready);
        fin      = adv && (left == 4'b0000);
        q_pop    = q_not_empty && (!cur_valid_reg || fin);

        cur_valid_next = q_pop ? 1'b1 : (fin ? 1'b0 : cur_valid_reg);
        rem_next       = rem_reg;
        done_next      = done_reg;
        if (adv) begin
            rem_next  = left;
            done_next = done_reg + 2'(sel_data);
        end
        if (q_pop) begin
            rem_next  = {q_head.status, q_head.keep};
            done_next = 2'd0;
        end
        ov_next = adv ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            rem_reg       <= 4'd0;
            done_reg      <= 2'd0;
            ov_reg        <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            rem_reg       <= rem_next;
            done_reg      <= done_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
        if (adv) begin
            ob_reg <= sel_data ? cur_reg.data[sel] : 8'd0;
            od_reg <= sel_data;
            ol_reg <= (left == 4'b0000);
            oc_reg <= cur_reg.base + 16'(done_reg) + 16'(sel_data);
            oh_reg <= sel_data ? 1'b0 : cur_reg.halt;
        end
    end

    assign out_valid    = ov_reg;
    assign out_byte     = ob_reg;
    assign is_data      = od_reg;
    assign last_of_run  = ol_reg;
    assign bytes_so_far = oc_reg;
    assign halted       = oh_reg;

    // a loaded entry always has work left
    a_cur_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> rem_reg != 4'b0000)
        else $error("active entry with no pending words");

endmodule

// ===== src/base64_decoder_unit.sv =====
// Top level of the streaming base64 decoder.
// Instantiates b64d_front, b64d_queue and b64d_back; uses b64d_pkg.
//
// Streaming base64 (standard alphabet) decoder. One character word enters per
// cycle on the input channel while in_ready is high; groups of four characters
// decode into up to three byte words, and a character flagged end_of_text adds
// one status word (is_data low) carrying the text's byte count and halt flag.
// Every word of a character is marked last_of_run on its final word. The front
// end classifies each character and closes groups in the cycle it accepts them,
// so input runs at one word per cycle while in_ready is high; the back end
// drains one output word per cycle while out_ready is high, so a character that
// completes a three-byte group and ends the text yields four output words. A
// small queue (QUEUE_DEPTH entries) between the two absorbs those bursts;
// in_ready drops only when the queue is full. An accepted character's words
// pass through the queue, the back end's entry register and the output
// register. The byte limit (limit_reg) caps the bytes per text and must be
// written through cfg_wr_en/cfg_wr_data only while the decoder is idle; the
// block does not enforce this. It resets to 65535.
module base64_decoder_unit #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        is_data,
    output logic        last_of_run,
    output logic [15:0] bytes_so_far,
    output logic        halted
);
    import b64d_pkg::*;

    logic [15:0] limit_reg, limit_next;
    logic        accept;
    logic        push;
    entry_t      push_entry;
    entry_t      head;
    logic        full;
    logic        not_empty;
    logic        pop;

    // hold the byte limit until a new value is written
    assign limit_next = cfg_wr_en ? cfg_wr_data : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            limit_reg <= 16'hFFFF;
        end else begin
            limit_reg <= limit_next;
        end
    end

    // take a character whenever the queue has room
    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    b64d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .limit       (limit_reg),
        .push        (push),
        .entry       (push_entry)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .not_empty  (not_empty)
    );

    b64d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (not_empty),
        .q_head       (head),
        .q_pop        (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .is_data      (is_data),
        .last_of_run  (last_of_run),
        .bytes_so_far (bytes_so_far),
        .halted       (halted)
    );

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for base64_decoder_unit: random and directed character streams,
// predicted byte/status words, scoreboard on the output channel.
// Depends on b64d_pkg and base64_decoder_unit from src.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;     // front plus queue plus back, with margin
    localparam int SHOW_LIMIT   = 20;     // cap on printed mismatches
    localparam int PHASE_CHARS  = 20;     // minimum random characters per limit setting

    // One character word on the input channel
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } char_item_t;

    // One word on the output channel
    typedef struct packed {
        logic [7:0]  value;
        logic        data;
        logic        last;
        logic [15:0] count;
        logic        halt;
    } out_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  char_code = 8'h00;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        is_data;
    logic        last_of_run;
    logic [15:0] bytes_so_far;
    logic        halted;

    base64_decoder_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .is_data      (is_data),
        .last_of_run  (last_of_run),
        .bytes_so_far (bytes_so_far),
        .halted       (halted)
    );

    initial forever #5 clk = ~clk;

    // Characters waiting to be sent, and words the decoder still owes us
    char_item_t pending_chars[$];
    out_word_t  owed_words[$];
    out_word_t  group_words[$];   // words of the character being decoded

    // Decoder state as predicted
    logic [15:0] byte_limit = 16'hFFFF;
    logic [1:0]  grp_pos = 2'd0;
    logic [5:0]  held[0:2] = '{6'd0, 6'd0, 6'd0};
    logic        pad_third = 1'b0;
    logic        halt_seen = 1'b0;
    logic        grp_bad = 1'b0;
    logic [15:0] text_bytes = 16'd0;

    // Run bookkeeping
    int  fault_count = 0;
    int  chars_taken = 0;
    int  texts_done = 0;
    int  halt_texts = 0;
    int  data_words = 0;
    int  status_words = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  hold_left = 0;
    bit  no_idle = 1'b0;
    char_item_t next_char;

    // Alphabet value of a character, SEXTET_BAD outside the alphabet
    function automatic logic [6:0] alphabet_index(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z") return 7'(ch - "A");
        if (ch >= "a" && ch <= "z") return 7'(ch - "a") + LOWER_BASE;
        if (ch >= "0" && ch <= "9") return 7'(ch - "0") + DIGIT_BASE;
        if (ch == "+") return SEXTET_PLUS;
        if (ch == "/") return SEXTET_DIV;
        return SEXTET_BAD;
    endfunction

    // Append a data word unless the text has hit its byte limit
    function automatic void add_byte(input logic [7:0] b);
        if (text_bytes < byte_limit) begin
            text_bytes = text_bytes + 16'd1;
            group_words.push_back('{b, 1'b1, 1'b0, text_bytes, halt_seen});
        end
    endfunction

    // Advance the predicted decoder by one accepted character and queue its words
    function automatic void decode_char(input logic [7:0] ch, input logic eot);
        logic [6:0] v;
        logic       pad;
        logic [5:0] s3;
        group_words.delete();
        if (!halt_seen) begin
            pad = (ch == CHAR_PAD);
            v = alphabet_index(ch);
            // pad counts as zero only in the back half of a group
            if (grp_pos >= 2'd2 && pad) v = 7'd0;
            if (v == SEXTET_BAD) begin
                grp_bad = 1'b1;
                v = 7'd0;
            end
            if (grp_pos != 2'd3) begin
                held[grp_pos] = v[5:0];
                if (grp_pos == 2'd2) pad_third = pad;
                grp_pos = grp_pos + 2'd1;
            end
            else begin
                s3 = v[5:0];
                // at the limit the group is not even examined
                if (text_bytes < byte_limit) begin
                    if (grp_bad) halt_seen = 1'b1;
                    else begin
                        add_byte({held[0], held[1][5:4]});
                        if (!pad_third) add_byte({held[1][3:0], held[2][5:2]});
                        if (!pad) add_byte({held[2][1:0], s3});
                    end
                end
                grp_pos = 2'd0;
                pad_third = 1'b0;
                grp_bad = 1'b0;
            end
        end
        if (eot) begin
            group_words.push_back('{8'h00, 1'b0, 1'b0, text_bytes, halt_seen});
            texts_done++;
            if (halt_seen) halt_texts++;
            grp_pos = 2'd0;
            held = '{6'd0, 6'd0, 6'd0};
            pad_third = 1'b0;
            halt_seen = 1'b0;
            grp_bad = 1'b0;
            text_bytes = 16'd0;
        end
        if (group_words.size() > 0) group_words[$].last = 1'b1;
        foreach (group_words[i]) owed_words.push_back(group_words[i]);
    endfunction

    // Mostly back-to-back, sometimes short waits, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 8);
        return $urandom_range(12, 25);
    endfunction

    // Input driver: predict on accept, then hold, idle or advance to the next character
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            char_code <= 8'h00;
            end_of_text <= 1'b0;
            send_gap = 0;
        end
        else begin
            if (in_valid && in_ready) begin
                decode_char(char_code, end_of_text);
                chars_taken++;
            end
            // hold the word until it is taken; otherwise the slot is free
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_chars.size() > 0) begin
                    next_char = pending_chars.pop_front();
                    char_code <= next_char.ch;
                    end_of_text <= next_char.eot;
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each accepted word against the oldest owed word
    always @(posedge clk or negedge rst_n) begin
        out_word_t got;
        out_word_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else begin
            if (out_valid === 1'b1 && out_ready) begin
                got = '{out_byte, is_data, last_of_run, bytes_so_far, halted};
                if (owed_words.size() == 0) begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT)
                        $display(
                            "%0t: unexpected byte=%02h data=%0b last=%0b count=%0d halt=%0b",
                            $time, got.value, got.data, got.last, got.count, got.halt);
                end
                else begin
                    want = owed_words.pop_front();
                    if (got.data === 1'b1) data_words++;
                    else status_words++;
                    if (got.value !== want.value || got.data !== want.data ||
                        got.last !== want.last || got.count !== want.count ||
                        got.halt !== want.halt) begin
                        fault_count++;
                        if (fault_count <= SHOW_LIMIT) begin
                            $display(
                                "%0t: expected byte=%02h data=%0b last=%0b count=%0d halt=%0b",
                                $time, want.value, want.data, want.last, want.count,
                                want.halt);
                            $display(
                                "%0t: actual   byte=%02h data=%0b last=%0b count=%0d halt=%0b",
                                $time, got.value, got.data, got.last, got.count,
                                got.halt);
                        end
                    end
                end
            end
            // stall the receiver now and then
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
                hold_left = pick_gap();
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still owed, %0d characters unsent",
                     $time, owed_words.size(), pending_chars.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // Queue one character
    task automatic send_char(input logic [7:0] ch, input logic eot);
        pending_chars.push_back('{ch, eot});
    endtask

    // Queue a string, flagging end of text on its last character if asked
    task automatic send_text(input string s, input logic eot);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], eot && (i == s.len() - 1));
    endtask

    // Random alphabet character
    function automatic logic [7:0] random_alpha();
        logic [7:0] v;
        v = 8'($urandom_range(0, 63));
        if (v < 8'd26) return "A" + v;
        if (v < 8'd52) return "a" + (v - 8'd26);
        if (v < 8'd62) return "0" + (v - 8'd52);
        return (v == 8'd62) ? "+" : "/";
    endfunction

    // Random text: whole groups, occasional padding, noise and a ragged tail
    task automatic send_random_text();
        char_item_t txt[$];
        int groups;
        int tail;
        int pad_style;
        logic [7:0] ch;
        groups = $urandom_range(0, 4);
        tail = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        for (int g = 0; g < groups; g++) begin
            pad_style = $urandom_range(0, 9);
            for (int p = 0; p < 4; p++) begin
                ch = random_alpha();
                if (pad_style == 0 && p >= 2) ch = CHAR_PAD;
                if (pad_style == 1 && p == 3) ch = CHAR_PAD;
                if (pad_style == 2 && p == 2) ch = CHAR_PAD;
                if ($urandom_range(0, 14) == 0) ch = 8'($urandom_range(0, 255));
                txt.push_back('{ch, 1'b0});
            end
        end
        for (int t = 0; t < tail; t++) begin
            ch = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : random_alpha();
            txt.push_back('{ch, 1'b0});
        end
        if (txt.size() == 0) txt.push_back('{random_alpha(), 1'b0});
        txt[$].eot = 1'b1;
        foreach (txt[i]) pending_chars.push_back(txt[i]);
    endtask

    // Wait for the decoder to drain, then cover characters that leave no word
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_chars.size() != 0 || in_valid || owed_words.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write the byte limit while idle; the predictor follows at the same edge
    task automatic write_limit(input logic [15:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        byte_limit = v;
        @(negedge clk);
    endtask

    initial begin
        logic [15:0] lim;
        int queued;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: full groups, both pad forms, pad in third place alone,
        // bad first/second and third places, alphabet ends, ragged tail
        write_limit(16'hFFFF);
        send_text("TWFu", 1'b0);
        send_text("TQ==", 1'b0);
        send_text("TW=A", 1'b1);
        send_char(CHAR_PAD, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("AA", 1'b1);
        send_text("AB", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CHAR_PAD, 1'b1);
        send_text("/+9zQ", 1'b1);
        wait_idle();
        // limit of zero: no bytes emitted and a bad group is never examined
        write_limit(16'h0000);
        send_text("*AAA", 1'b1);
        wait_idle();

        // Random phases across limit settings; phase 4 runs with no idling
        for (int phase = 1; phase <= 6; phase++) begin
            case (phase)
                1: lim = 16'h0000;
                2: lim = 16'h0001;
                3: lim = 16'($urandom_range(2, 12));
                4: lim = 16'hFFFF;
                5: lim = 16'($urandom_range(0, 65535));
                default: lim = 16'hFFFE;
            endcase
            no_idle = (phase == 4);
            write_limit(lim);
            queued = 0;
            while (queued < PHASE_CHARS) begin
                queued -= pending_chars.size();
                send_random_text();
                queued += pending_chars.size();
            end
            wait_idle();
        end

        if (owed_words.size() != 0) begin
            fault_count++;
            $display("%0t: %0d expected words never arrived", $time, owed_words.size());
        end
        $display("run: %0d characters over %0d texts, %0d halted, limits 0 to 65535",
                 chars_taken, texts_done, halt_texts);
        $display("run: %0d byte words and %0d status words compared, %0d faults",
                 data_words, status_words, fault_count);
        if (fault_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/b64d_pkg.sv
src/b64d_front.sv
src/b64d_queue.sv
src/b64d_back.sv
src/base64_decoder_unit.sv
sim/testbench.sv
